// ===== hdl/swp_pkg.sv =====
// Shared types and constants for the single-wire pulse slave receiver.
// Holds the phase and event codes, the result beat struct and the wait lengths.
// No dependencies.
package swp_pkg;

    // Field widths and defaults of the bus format.
    localparam int ADDRESS_BITS_DEFAULT = 8;
    localparam int DATA_BITS_DEFAULT    = 16;
    localparam int OWN_ADDR_BITS        = 8;
    localparam int WORD_BITS            = 16;
    localparam int UNITS_BITS           = 4;
    localparam int BIT_INDEX_BITS       = 6;
    localparam int QUEUE_DEPTH          = 2;

    // Wait lengths in time units.
    localparam logic [UNITS_BITS-1:0] WAIT_START = 4'd15;
    localparam logic [UNITS_BITS-1:0] WAIT_BIT   = 4'd5;
    localparam logic [UNITS_BITS-1:0] WAIT_ACK   = 4'd8;
    localparam logic [UNITS_BITS-1:0] WAIT_NONE  = 4'd0;

    // The bit counter stops at its top value.
    localparam logic [BIT_INDEX_BITS-1:0] BIT_INDEX_MAX = 6'd63;

    // Frame phase.
    typedef enum logic [1:0] {
        PH_IDLE    = 2'd0,
        PH_ADDRESS = 2'd1,
        PH_DATA    = 2'd2,
        PH_END     = 2'd3
    } t_phase;

    // Classified bus event.
    typedef enum logic [1:0] {
        EV_EDGE_LOW      = 2'd0,
        EV_EDGE_HIGH     = 2'd1,
        EV_WAIT_END_LOW  = 2'd2,
        EV_WAIT_END_HIGH = 2'd3
    } t_event;

    // One result beat.
    typedef struct packed {
        logic                  drive_low;
        logic                  wait_request;
        logic [UNITS_BITS-1:0] wait_units;
        logic                  word_valid;
        logic [WORD_BITS-1:0]  word_value;
        logic                  frame_reset;
    } t_result;

endpackage

// ===== hdl/swp_fifo.sv =====
// Small register-based first-in first-out queue of generic width and depth.
// Used between the front and back ends and as the result buffer.
// No package dependencies.
module swp_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_data,
    output logic             o_empty
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PW-1:0]    r_wr_ptr, n_wr_ptr;
    logic [PW-1:0]    r_rd_ptr, n_rd_ptr;
    logic [CW-1:0]    r_count, n_count;
    logic             do_push, do_pop;

    assign o_full  = (r_count == CW'(DEPTH));
    assign o_empty = (r_count == '0);
    assign o_data  = r_mem[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    // Pointer and fill count update, with wrap at the queue depth.
    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (do_push) begin
            n_wr_ptr = (r_wr_ptr == PW'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (do_pop) begin
            n_rd_ptr = (r_rd_ptr == PW'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (do_push && !do_pop) begin
            n_count = r_count + 1'b1;
        end else if (do_pop && !do_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // Storage needs no reset.
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

endmodule

// ===== hdl/swp_front.sv =====
// Front end: accepts bus events, classifies them and queues them.
// Depends on swp_pkg and swp_fifo.
module swp_front
    import swp_pkg::*;
(
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_push,
    input  logic   i_kind,
    input  logic   i_line_level,
    output logic   o_full,
    input  logic   i_ev_pop,
    output t_event o_ev,
    output logic   o_ev_empty
);

    t_event                    ev_code;
    logic [$bits(t_event)-1:0] ev_raw;

    // Map the raw kind and level onto an event code.
    always_comb begin
        case ({i_kind, i_line_level})
            2'b00:   ev_code = EV_EDGE_LOW;
            2'b01:   ev_code = EV_EDGE_HIGH;
            2'b10:   ev_code = EV_WAIT_END_LOW;
            2'b11:   ev_code = EV_WAIT_END_HIGH;
            default: ev_code = EV_EDGE_LOW;
        endcase
    end

    // Event queue towards the back end.
    swp_fifo #(
        .WIDTH ($bits(t_event)),
        .DEPTH (QUEUE_DEPTH)
    ) u_ev_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (i_push),
        .i_data  (ev_code),
        .o_full  (o_full),
        .i_pop   (i_ev_pop),
        .o_data  (ev_raw),
        .o_empty (o_ev_empty)
    );

    // The queue holds plain bits; hand the head on as an event code.
    assign o_ev = t_event'(ev_raw);

endmodule

// ===== hdl/swp_back.sv =====
// Back end: frame state machine that carries out queued events and buffers results.
// Depends on swp_pkg and swp_fifo.
module swp_back
    import swp_pkg::*;
#(
    parameter int ADDRESS_BITS = ADDRESS_BITS_DEFAULT,
    parameter int DATA_BITS    = DATA_BITS_DEFAULT
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_cfg_wr_en,
    input  logic [OWN_ADDR_BITS-1:0] i_cfg_wr_data,
    input  t_event                   i_ev,
    input  logic                     i_ev_empty,
    output logic                     o_ev_pop,
    output t_result                  o_res,
    output logic                     o_res_empty,
    input  logic                     i_res_pop
);

    localparam int AIW       = (ADDRESS_BITS > 1) ? $clog2(ADDRESS_BITS) : 1;
    localparam int DIW       = (DATA_BITS > 1) ? $clog2(DATA_BITS) : 1;
    localparam int CMP_BITS  = (ADDRESS_BITS > OWN_ADDR_BITS) ? ADDRESS_BITS : OWN_ADDR_BITS;
    localparam int WORD_KEEP = (DATA_BITS < WORD_BITS) ? DATA_BITS : WORD_BITS;

    logic [OWN_ADDR_BITS-1:0]  r_own_address;
    t_phase                    r_phase, n_phase;
    logic                      r_waiting, n_waiting;
    logic                      r_acking, n_acking;
    logic                      r_sampled, n_sampled;
    logic [BIT_INDEX_BITS-1:0] r_bit_index, n_bit_index;
    logic [ADDRESS_BITS-1:0]   r_addr_shift, n_addr_shift;
    logic [DATA_BITS-1:0]      r_data_shift, n_data_shift;
    logic                      r_line_drive, n_line_drive;

    logic    res_full, step, clear, level, is_addr, bit_in_field, addr_match;
    t_result res;

    // An event is carried out when a result slot is free.
    assign step     = !i_ev_empty && !res_full;
    assign o_ev_pop = step;
    assign level    = (i_ev == EV_EDGE_HIGH) || (i_ev == EV_WAIT_END_HIGH);
    assign is_addr  = (r_phase == PH_ADDRESS);

    assign bit_in_field = is_addr ? (r_bit_index < BIT_INDEX_BITS'(ADDRESS_BITS))
                                  : (r_bit_index < BIT_INDEX_BITS'(DATA_BITS));
    assign addr_match   = (CMP_BITS'(r_addr_shift) == CMP_BITS'(r_own_address));

    // Own address register, loaded from the configuration port.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_own_address <= '0;
        end else if (i_cfg_wr_en) begin
            r_own_address <= i_cfg_wr_data;
        end
    end

    // Frame state registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= PH_IDLE;
            r_waiting    <= 1'b0;
            r_acking     <= 1'b0;
            r_sampled    <= 1'b1;
            r_bit_index  <= '0;
            r_addr_shift <= '0;
            r_data_shift <= '0;
            r_line_drive <= 1'b0;
        end else if (step) begin
            r_phase      <= n_phase;
            r_waiting    <= n_waiting;
            r_acking     <= n_acking;
            r_sampled    <= n_sampled;
            r_bit_index  <= n_bit_index;
            r_addr_shift <= n_addr_shift;
            r_data_shift <= n_data_shift;
            r_line_drive <= n_line_drive;
        end
    end

    // Next state and result for the event at the head of the queue.
    always_comb begin
        n_phase      = r_phase;
        n_waiting    = r_waiting;
        n_acking     = r_acking;
        n_sampled    = r_sampled;
        n_bit_index  = r_bit_index;
        n_addr_shift = r_addr_shift;
        n_data_shift = r_data_shift;
        n_line_drive = r_line_drive;
        clear        = 1'b0;
        res          = '0;

        if ((i_ev == EV_WAIT_END_LOW) || (i_ev == EV_WAIT_END_HIGH)) begin
            // End of a requested wait: sample the line and stop any acknowledge.
            n_sampled = level;
            n_waiting = 1'b0;
            if (r_acking) begin
                n_line_drive = 1'b0;
                n_acking     = 1'b0;
            end
            if (r_phase == PH_END) begin
                res.word_valid = 1'b1;
                res.word_value = WORD_BITS'(r_data_shift[WORD_KEEP-1:0]);
                clear          = 1'b1;
            end
        end else begin
            case (r_phase)
                PH_IDLE: begin
                    // Start pulse: falling edge opens the long wait.
                    if (!level) begin
                        if (!r_waiting) begin
                            n_waiting        = 1'b1;
                            res.wait_request = 1'b1;
                            res.wait_units   = WAIT_START;
                        end else begin
                            clear = 1'b1;
                        end
                    end else if (!r_waiting && !r_sampled) begin
                        n_phase = PH_ADDRESS;
                    end else begin
                        clear = 1'b1;
                    end
                end
                PH_ADDRESS, PH_DATA: begin
                    if (!level) begin
                        // Falling edge: next bit, or acknowledge once the field is full.
                        if (r_waiting) begin
                            clear = 1'b1;
                        end else if (bit_in_field) begin
                            n_waiting        = 1'b1;
                            res.wait_request = 1'b1;
                            res.wait_units   = WAIT_BIT;
                        end else if (is_addr && !addr_match) begin
                            clear = 1'b1;
                        end else begin
                            n_acking         = 1'b1;
                            n_line_drive     = 1'b1;
                            n_waiting        = 1'b1;
                            res.wait_request = 1'b1;
                            res.wait_units   = WAIT_ACK;
                            if (is_addr) begin
                                n_bit_index = '0;
                                n_phase     = PH_DATA;
                            end else begin
                                n_phase = PH_END;
                            end
                        end
                    end else if (r_waiting || !r_sampled) begin
                        // Rising edge ends the bit; a one bit is stored if it fits.
                        if (!r_waiting && bit_in_field) begin
                            if (is_addr) begin
                                n_addr_shift[r_bit_index[AIW-1:0]] = 1'b1;
                            end else begin
                                n_data_shift[r_bit_index[DIW-1:0]] = 1'b1;
                            end
                        end
                        if (r_bit_index != BIT_INDEX_MAX) begin
                            n_bit_index = r_bit_index + 1'b1;
                        end
                    end else begin
                        clear = 1'b1;
                    end
                end
                default: begin
                    // Any edge during the final acknowledge is a violation.
                    clear = 1'b1;
                end
            endcase
        end

        // Return to idle releases the line and clears the frame.
        if (clear) begin
            n_phase      = PH_IDLE;
            n_waiting    = 1'b0;
            n_acking     = 1'b0;
            n_sampled    = 1'b1;
            n_bit_index  = '0;
            n_addr_shift = '0;
            n_data_shift = '0;
            n_line_drive = 1'b0;
        end
        res.frame_reset = clear;
        res.drive_low   = n_line_drive;
    end

    // Result buffer towards the receiver.
    swp_fifo #(
        .WIDTH ($bits(t_result)),
        .DEPTH (QUEUE_DEPTH)
    ) u_res_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (step),
        .i_data  (res),
        .o_full  (res_full),
        .i_pop   (i_res_pop),
        .o_data  (o_res),
        .o_empty (o_res_empty)
    );

    // The line is driven exactly while an acknowledge is in progress.
    a_drive_acking: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_line_drive == r_acking)
        else $error("line drive and acknowledge flag disagree");

    // A delivered word always ends the frame.
    a_word_ends_frame: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (step && res.word_valid) |-> res.frame_reset)
        else $error("word delivered without frame reset");

    // A frame reset leaves the machine idle with nothing pending.
    a_reset_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (step && res.frame_reset) |=> (r_phase == PH_IDLE && !r_waiting && !r_acking))
        else $error("frame reset did not return to idle");

    // An event is only consumed when its result can be stored.
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_ev_pop |-> (!res_full && !i_ev_empty))
        else $error("event consumed without room for its result");

endmodule

// ===== hdl/single_wire_pulse_slave_receiver.sv =====
// Top level of the single-wire pulse-width-coded bus slave receiver.
// Depends on swp_pkg, swp_front, swp_back and swp_fifo.
//
// Usage:
//   Bus events enter on the input queue: present i_kind (0 line edge, 1 end of
//   a requested wait) and i_line_level with push; a beat is taken at a clock
//   edge with push high and full low. Every event yields exactly one result
//   beat on the output queue: while empty is low the oldest result is on the
//   o_ ports, and it is taken at a clock edge with pop high.
//   The own address is written through i_cfg_wr_en and i_cfg_wr_data; the user
//   must do this only while no frame is in flight, as the block does not check it.
// Flow and throughput:
//   A result reaches the o_ ports once its event has been taken into the front
//   event queue, worked on by the state machine at the head of that queue, and
//   its result pushed into the result queue. The state machine retires one event
//   per cycle while the result queue has room, so one event per cycle is
//   sustained while the receiver keeps popping.
// Reset and stalls:
//   Synchronous active-low reset empties both queues, returns the frame to
//   idle, releases the line and clears the own address. If the receiver stops
//   popping, the result queue fills, the state machine holds, the event queue
//   fills and full rises; nothing is lost.
module single_wire_pulse_slave_receiver
    import swp_pkg::*;
#(
    parameter int ADDRESS_BITS = ADDRESS_BITS_DEFAULT,
    parameter int DATA_BITS    = DATA_BITS_DEFAULT
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_cfg_wr_en,
    input  logic [OWN_ADDR_BITS-1:0] i_cfg_wr_data,
    input  logic                     push,
    output logic                     full,
    input  logic                     i_kind,
    input  logic                     i_line_level,
    output logic                     empty,
    input  logic                     pop,
    output logic                     o_drive_low,
    output logic                     o_wait_request,
    output logic [UNITS_BITS-1:0]    o_wait_units,
    output logic                     o_word_valid,
    output logic [WORD_BITS-1:0]     o_word_value,
    output logic                     o_frame_reset
);

    t_event  ev;
    logic    ev_empty, ev_pop;
    t_result res;

    swp_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (push),
        .i_kind       (i_kind),
        .i_line_level (i_line_level),
        .o_full       (full),
        .i_ev_pop     (ev_pop),
        .o_ev         (ev),
        .o_ev_empty   (ev_empty)
    );

    swp_back #(
        .ADDRESS_BITS (ADDRESS_BITS),
        .DATA_BITS    (DATA_BITS)
    ) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_ev          (ev),
        .i_ev_empty    (ev_empty),
        .o_ev_pop      (ev_pop),
        .o_res         (res),
        .o_res_empty   (empty),
        .i_res_pop     (pop)
    );

    // Unpack the result beat onto the output ports.
    assign o_drive_low    = res.drive_low;
    assign o_wait_request = res.wait_request;
    assign o_wait_units   = res.wait_units;
    assign o_word_valid   = res.word_valid;
    assign o_word_value   = res.word_value;
    assign o_frame_reset  = res.frame_reset;

endmodule

// ===== bench/tb_top.sv =====
// Self-checking testbench for single_wire_pulse_slave_receiver.
// Holds a behavioural model of the bus slave, a queue-fed driver and a checking monitor.
// Depends on swp_pkg and the RTL of the receiver.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import swp_pkg::*;

    // Event kinds as they appear on i_kind.
    localparam logic KIND_EDGE     = 1'b0;
    localparam logic KIND_WAIT_END = 1'b1;

    // Ways a generated frame may be shaped.
    localparam int FRAME_CLEAN    = 0;
    localparam int FRAME_BROKEN   = 1;
    localparam int FRAME_END_EDGE = 2;

    localparam int CYCLE_LIMIT  = 1_000_000;
    localparam int RANDOM_ITEMS = 1550;
    localparam int NUM_PHASES   = 8;
    localparam int LONG_HOLD    = 300;
    localparam int SETTLE       = 10;

    typedef struct packed {
        logic kind;
        logic level;
    } t_bus_event;

    // Clock, reset and DUT connections.
    logic                     clk = 1'b0;
    logic                     rst_n = 1'b0;
    logic                     cfg_wr_en = 1'b0;
    logic [OWN_ADDR_BITS-1:0] cfg_wr_data = '0;
    logic                     push = 1'b0;
    logic                     full;
    logic                     ev_kind = 1'b0;
    logic                     ev_level = 1'b1;
    logic                     empty;
    logic                     pop = 1'b0;
    logic                     o_drive_low;
    logic                     o_wait_request;
    logic [UNITS_BITS-1:0]    o_wait_units;
    logic                     o_word_valid;
    logic [WORD_BITS-1:0]     o_word_value;
    logic                     o_frame_reset;

    // Stimulus and expectation stores.
    t_bus_event pending_events[$];
    t_bus_event frame_buf[$];
    t_result    expected_results[$];

    int  err_count = 0;
    int  cycle_count = 0;
    int  items_taken = 0;
    int  n_added = 0;
    int  send_gap_left = 0;
    int  recv_hold_left = 0;
    bit  long_hold_done = 1'b0;
    bit  sender_idles = 1'b1;
    bit  receiver_idles = 1'b1;

    // Model of the slave's frame state.
    t_phase                   bus_phase;
    logic                     bus_waiting;
    logic                     bus_acking;
    logic                     bus_sampled;
    logic [BIT_INDEX_BITS-1:0] bus_bit_idx;
    logic [7:0]               bus_addr_sr;
    logic [15:0]              bus_data_sr;
    logic                     bus_drive;
    logic [OWN_ADDR_BITS-1:0] own_addr_m = '0;

    single_wire_pulse_slave_receiver DUT (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_cfg_wr_en    (cfg_wr_en),
        .i_cfg_wr_data  (cfg_wr_data),
        .push           (push),
        .full           (full),
        .i_kind         (ev_kind),
        .i_line_level   (ev_level),
        .empty          (empty),
        .pop            (pop),
        .o_drive_low    (o_drive_low),
        .o_wait_request (o_wait_request),
        .o_wait_units   (o_wait_units),
        .o_word_valid   (o_word_valid),
        .o_word_value   (o_word_value),
        .o_frame_reset  (o_frame_reset)
    );

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Run limit: a hung handshake ends the run as a failure.
    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    // Return the frame state to idle; the own address is kept.
    function automatic void frame_clear();
        bus_phase   = PH_IDLE;
        bus_waiting = 1'b0;
        bus_acking  = 1'b0;
        bus_sampled = 1'b1;
        bus_bit_idx = '0;
        bus_addr_sr = '0;
        bus_data_sr = '0;
        bus_drive   = 1'b0;
    endfunction

    function automatic void bit_advance();
        if (bus_bit_idx != BIT_INDEX_MAX) bus_bit_idx = bus_bit_idx + 1'b1;
    endfunction

    // Work out the result beat of one accepted event and queue it.
    function automatic void predict_bus_event(input logic kind, input logic level);
        t_result r;
        logic    is_addr;
        int      nbits;
        r = '0;
        if (kind == KIND_WAIT_END) begin
            bus_sampled = level;
            bus_waiting = 1'b0;
            if (bus_acking) begin
                bus_drive  = 1'b0;
                bus_acking = 1'b0;
            end
            if (bus_phase == PH_END) begin
                r.word_valid  = 1'b1;
                r.word_value  = bus_data_sr;
                r.frame_reset = 1'b1;
                frame_clear();
            end
        end else if (bus_phase == PH_IDLE) begin
            if (level == 1'b0) begin
                if (!bus_waiting) begin
                    bus_waiting    = 1'b1;
                    r.wait_request = 1'b1;
                    r.wait_units   = WAIT_START;
                end else begin
                    frame_clear();
                    r.frame_reset = 1'b1;
                end
            end else if (!bus_waiting && bus_sampled == 1'b0) begin
                bus_phase = PH_ADDRESS;
            end else begin
                frame_clear();
                r.frame_reset = 1'b1;
            end
        end else if (bus_phase == PH_ADDRESS || bus_phase == PH_DATA) begin
            is_addr = (bus_phase == PH_ADDRESS);
            nbits   = is_addr ? ADDRESS_BITS_DEFAULT : DATA_BITS_DEFAULT;
            if (level == 1'b0) begin
                if (bus_waiting) begin
                    frame_clear();
                    r.frame_reset = 1'b1;
                end else if (int'(bus_bit_idx) < nbits) begin
                    bus_waiting    = 1'b1;
                    r.wait_request = 1'b1;
                    r.wait_units   = WAIT_BIT;
                end else if (is_addr && bus_addr_sr != own_addr_m) begin
                    frame_clear();
                    r.frame_reset = 1'b1;
                end else begin
                    // Acknowledge: pull the line low for the ack wait.
                    bus_acking     = 1'b1;
                    bus_drive      = 1'b1;
                    bus_waiting    = 1'b1;
                    r.wait_request = 1'b1;
                    r.wait_units   = WAIT_ACK;
                    if (is_addr) begin
                        bus_bit_idx = '0;
                        bus_phase   = PH_DATA;
                    end else begin
                        bus_phase = PH_END;
                    end
                end
            end else if (bus_waiting) begin
                bit_advance();
            end else if (bus_sampled == 1'b0) begin
                // A one bit beyond the field width is counted but not stored.
                if (int'(bus_bit_idx) < nbits) begin
                    if (is_addr) bus_addr_sr[bus_bit_idx[2:0]] = 1'b1;
                    else bus_data_sr[bus_bit_idx[3:0]] = 1'b1;
                end
                bit_advance();
            end else begin
                frame_clear();
                r.frame_reset = 1'b1;
            end
        end else begin
            // Any edge in the end phase is a violation.
            frame_clear();
            r.frame_reset = 1'b1;
        end
        r.drive_low = bus_drive;
        expected_results.push_back(r);
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70) return 0;
        else if (r < 95) return $urandom_range(1, 3);
        else return $urandom_range(10, 40);
    endfunction

    // Driver: offers pending events, holding each until the DUT takes the beat.
    always @(posedge clk) begin
        if (!rst_n) begin
            push <= 1'b0;
        end else begin
            if (push && !full) begin
                predict_bus_event(ev_kind, ev_level);
                items_taken <= items_taken + 1;
            end
            if (push && full) begin
                push <= 1'b1;
            end else if (send_gap_left != 0) begin
                push          <= 1'b0;
                send_gap_left <= send_gap_left - 1;
            end else if (pending_events.size() != 0) begin
                push          <= 1'b1;
                ev_kind       <= pending_events[0].kind;
                ev_level      <= pending_events[0].level;
                send_gap_left <= sender_idles ? pick_gap() : 0;
                void'(pending_events.pop_front());
            end else begin
                push <= 1'b0;
            end
        end
    end

    // Monitor: takes result beats and checks them against the oldest expectation.
    always @(posedge clk) begin
        if (!rst_n) begin
            pop <= 1'b0;
        end else begin
            if (pop && !empty) begin
                if (expected_results.size() == 0) begin
                    $error("result beat arrived with no expectation waiting");
                    err_count++;
                end else begin
                    if (o_drive_low !== expected_results[0].drive_low) begin
                        $error("drive_low: expected %0d, got %0d",
                               expected_results[0].drive_low, o_drive_low);
                        err_count++;
                    end
                    if (o_wait_request !== expected_results[0].wait_request) begin
                        $error("wait_request: expected %0d, got %0d",
                               expected_results[0].wait_request, o_wait_request);
                        err_count++;
                    end
                    if (o_wait_units !== expected_results[0].wait_units) begin
                        $error("wait_units: expected %0d, got %0d",
                               expected_results[0].wait_units, o_wait_units);
                        err_count++;
                    end
                    if (o_word_valid !== expected_results[0].word_valid) begin
                        $error("word_valid: expected %0d, got %0d",
                               expected_results[0].word_valid, o_word_valid);
                        err_count++;
                    end
                    if (o_word_value !== expected_results[0].word_value) begin
                        $error("word_value: expected %0h, got %0h",
                               expected_results[0].word_value, o_word_value);
                        err_count++;
                    end
                    if (o_frame_reset !== expected_results[0].frame_reset) begin
                        $error("frame_reset: expected %0d, got %0d",
                               expected_results[0].frame_reset, o_frame_reset);
                        err_count++;
                    end
                    void'(expected_results.pop_front());
                end
            end
            // One long hold-off part way through, so that both queues fill up.
            if (!long_hold_done && items_taken >= 400) begin
                long_hold_done <= 1'b1;
                recv_hold_left <= LONG_HOLD;
                pop            <= 1'b0;
            end else if (recv_hold_left != 0) begin
                recv_hold_left <= recv_hold_left - 1;
                pop            <= 1'b0;
            end else if (receiver_idles && $urandom_range(0, 3) == 0) begin
                recv_hold_left <= pick_gap();
                pop            <= 1'b0;
            end else begin
                pop <= 1'b1;
            end
        end
    end

    // Stimulus helpers: events are built up in frame_buf, then handed to the driver.
    task automatic put(input logic kind, input logic level);
        t_bus_event ev;
        ev.kind  = kind;
        ev.level = level;
        frame_buf.push_back(ev);
    endtask

    // A bit reads as one if the line is still low when the bit wait ends.
    task automatic put_bit(input logic value);
        put(KIND_EDGE, 1'b0);
        if (value) begin
            put(KIND_WAIT_END, 1'b0);
            put(KIND_EDGE, 1'b1);
        end else begin
            put(KIND_EDGE, 1'b1);
            put(KIND_WAIT_END, 1'b1);
        end
    endtask

    task automatic flush_frame(input bit broken);
        int pos;
        if (broken && frame_buf.size() != 0) begin
            pos = $urandom_range(0, frame_buf.size() - 1);
            if ($urandom_range(0, 1) == 0) begin
                frame_buf[pos].kind  = 1'($urandom_range(0, 1));
                frame_buf[pos].level = 1'($urandom_range(0, 1));
            end else begin
                while (frame_buf.size() > pos) void'(frame_buf.pop_back());
            end
        end
        n_added += frame_buf.size();
        while (frame_buf.size() != 0) pending_events.push_back(frame_buf.pop_front());
    endtask

    task automatic put_data_tail(input logic [15:0] data, input bit end_edge);
        int i;
        for (i = 0; i < DATA_BITS_DEFAULT; i++) put_bit(data[i]);
        put(KIND_EDGE, 1'b0);
        put(end_edge ? KIND_EDGE : KIND_WAIT_END, 1'($urandom_range(0, 1)));
    endtask

    task automatic put_frame(input logic [7:0] addr, input logic [15:0] data, input int shape);
        int i;
        put(KIND_EDGE, 1'b0);
        put(KIND_WAIT_END, 1'b0);
        put(KIND_EDGE, 1'b1);
        for (i = 0; i < ADDRESS_BITS_DEFAULT; i++) put_bit(addr[i]);
        put(KIND_EDGE, 1'b0);
        put(KIND_WAIT_END, 1'($urandom_range(0, 1)));
        put_data_tail(data, shape == FRAME_END_EDGE);
        flush_frame(shape == FRAME_BROKEN);
    endtask

    // A run of rising edges after a one bit keeps counting past the address width.
    task automatic put_overrun(input int run, input logic [15:0] data);
        put(KIND_EDGE, 1'b0);
        put(KIND_WAIT_END, 1'b0);
        put(KIND_EDGE, 1'b1);
        put(KIND_EDGE, 1'b0);
        put(KIND_WAIT_END, 1'b0);
        repeat (run) put(KIND_EDGE, 1'b1);
        put(KIND_EDGE, 1'b0);
        put(KIND_WAIT_END, 1'($urandom_range(0, 1)));
        put_data_tail(data, 1'b0);
        flush_frame(1'b0);
    endtask

    task automatic wait_drained();
        while (pending_events.size() != 0 || push || expected_results.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_own_address(input logic [OWN_ADDR_BITS-1:0] value);
        @(posedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        own_addr_m   = value;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
    endtask

    // Main sequence: reset, directed events, then randomised phases.
    initial begin
        logic [OWN_ADDR_BITS-1:0] phase_addr[NUM_PHASES];
        logic [7:0]               addr;
        logic [15:0]              data;
        int                       p;
        int                       r;
        int                       target;

        phase_addr = '{8'h00, 8'hFF, 8'h5A, 8'($urandom), 8'h80, 8'h01,
                       8'($urandom), 8'hA5};
        frame_clear();
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: idle corner cases, short start pulses, early violations.
        @(negedge clk);
        put(KIND_WAIT_END, 1'b1);
        put(KIND_EDGE, 1'b1);
        put(KIND_EDGE, 1'b0);
        put(KIND_EDGE, 1'b0);
        put(KIND_EDGE, 1'b0);
        put(KIND_EDGE, 1'b1);
        put(KIND_EDGE, 1'b0);
        put(KIND_WAIT_END, 1'b1);
        put(KIND_EDGE, 1'b1);
        put(KIND_EDGE, 1'b0);
        put(KIND_WAIT_END, 1'b0);
        put(KIND_EDGE, 1'b1);
        put(KIND_EDGE, 1'b1);
        put(KIND_EDGE, 1'b0);
        put(KIND_EDGE, 1'b0);
        put(KIND_WAIT_END, 1'b0);
        put(KIND_EDGE, 1'b1);
        put(KIND_EDGE, 1'b0);
        put(KIND_WAIT_END, 1'b1);
        put(KIND_EDGE, 1'b1);
        put(KIND_WAIT_END, 1'b0);
        put(KIND_EDGE, 1'b1);
        put(KIND_EDGE, 1'b0);
        put(KIND_WAIT_END, 1'b0);
        put(KIND_EDGE, 1'b1);
        flush_frame(1'b0);

        // Random phases, each with its own address; some run without idling.
        n_added = 0;
        for (p = 0; p < NUM_PHASES; p++) begin
            wait_drained();
            write_own_address(phase_addr[p]);
            sender_idles   = (p % 3 != 1);
            receiver_idles = (p % 3 != 2);
            target         = (p + 1) * RANDOM_ITEMS / NUM_PHASES;
            @(negedge clk);
            if (p == 0) begin
                put_frame(own_addr_m, 16'hFFFF, FRAME_CLEAN);
                put_frame(own_addr_m, 16'h0000, FRAME_CLEAN);
                put_frame(own_addr_m, 16'h8001, FRAME_END_EDGE);
            end
            while (n_added < target) begin
                r    = $urandom_range(0, 99);
                addr = ($urandom_range(0, 4) != 0) ? own_addr_m : 8'($urandom);
                case ($urandom_range(0, 9))
                    0: data = 16'hFFFF;
                    1: data = 16'h0000;
                    default: data = 16'($urandom);
                endcase
                if (r < 60) begin
                    put_frame(addr, data, FRAME_CLEAN);
                end else if (r < 75) begin
                    put_frame(addr, data, FRAME_BROKEN);
                end else if (r < 82) begin
                    put_frame(addr, data, FRAME_END_EDGE);
                end else if (r < 87) begin
                    put_overrun($urandom_range(1, 75), data);
                end else begin
                    repeat ($urandom_range(1, 12))
                        put(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
                    flush_frame(1'b0);
                end
            end
        end

        wait_drained();
        repeat (SETTLE) @(posedge clk);
        if (err_count == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
